// ----- hw/rtl/assert_macros.svh -----
// Concurrent assertion macros for the commit window tracker.
// Expects clk and arst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CWT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define CWT_ASSERT_IMP(lbl, ante, cons, msg) \
	`CWT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- hw/rtl/cwt_pkg.sv -----
// Shared types and constants for the commit window tracker.
// No dependencies; imported by every module of the block.
package cwt_pkg;

	localparam int ID_W         = 64;
	localparam int BIT_W        = $clog2(ID_W);
	localparam int ADVANCE_STEP = 16;
	localparam int ADV_LOG2     = $clog2(ADVANCE_STEP);

	typedef enum logic [2:0] {
		F_COMMIT = 3'd0,
		F_SNAP   = 3'd1,
		F_CHECK  = 3'd2,
		F_START  = 3'd3,
		F_SETB   = 3'd4
	} func_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [3:0] {
		S_BOOT,
		S_IDLE,
		S_MOD,
		S_WRITE,
		S_CLR,
		S_WSTART,
		S_WCMP,
		S_WINC,
		S_ADV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic  req_valid;
		func_t req_func;
		func_t cur_func;
		logic  succeeded;
		logic  pow2;
		logic  out_free;
		logic  mod_last;
		logic  sweep_last;
		logic  walk_last;
		logic  tag_eq;
		logic  missed;
	} status_t;

	typedef struct packed {
		state_t state;
		logic   req_ready;
	} ctrl_t;

endpackage

// ----- hw/rtl/cwt_alu.sv -----
// Shared 64-bit add/subtract unit with borrow and zero flags.
// Depends on cwt_pkg.
module cwt_alu import cwt_pkg::*; (
	input  alu_op_t          op,
	input  logic [ID_W-1:0]  a,
	input  logic [ID_W-1:0]  b,
	output logic [ID_W-1:0]  y,
	output logic             borrow,
	output logic             zero
);

	logic [ID_W:0] full;

	always_comb begin
		case (op)
			ALU_ADD: full = {1'b0, a} + {1'b0, b};
			ALU_SUB: full = {1'b0, a} - {1'b0, b};
			default: full = '0;
		endcase
	end

	assign y      = full[ID_W-1:0];
	assign borrow = (op == ALU_SUB) && full[ID_W];
	assign zero   = (full[ID_W-1:0] == '0);

endmodule

// ----- hw/rtl/cwt_slot_ram.sv -----
// Slot tag memory: one write port, one read port with registered data.
// Depends on cwt_pkg.
module cwt_slot_ram import cwt_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [ID_W-1:0]  wdata,
	input  logic [AW-1:0]    raddr,
	output logic [ID_W-1:0]  rdata
);

	logic [ID_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/cwt_seq.sv -----
// Sequencer for the commit window tracker: state register and next-state logic.
// Depends on cwt_pkg; driven by status from the top-level datapath.
module cwt_seq import cwt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t st,
	output ctrl_t   ctrl
);

	state_t state_q, state_d, route;

	always_comb begin
		case (st.cur_func)
			F_COMMIT: route = S_WRITE;
			F_START:  route = S_CLR;
			default:  route = S_DONE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_BOOT: begin
				if (st.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (st.req_valid) begin
					case (st.req_func)
						F_COMMIT: begin
							if (!st.succeeded) state_d = S_DONE;
							else state_d = st.pow2 ? S_WRITE : S_MOD;
						end
						F_SNAP, F_CHECK: state_d = S_WSTART;
						F_START: state_d = st.pow2 ? S_CLR : S_MOD;
						F_SETB:  state_d = st.pow2 ? S_DONE : S_MOD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_MOD: begin
				if (st.mod_last) state_d = route;
			end
			S_WRITE: state_d = S_DONE;
			S_CLR: begin
				if (st.sweep_last) state_d = S_DONE;
			end
			S_WSTART: state_d = S_WCMP;
			S_WCMP: begin
				if (st.cur_func == F_CHECK) begin
					if ((st.tag_eq && st.missed) || st.walk_last) state_d = S_DONE;
					else state_d = S_WINC;
				end else begin
					if (!st.tag_eq || st.walk_last) state_d = S_ADV;
					else state_d = S_WINC;
				end
			end
			S_WINC: state_d = S_WCMP;
			S_ADV:  state_d = S_DONE;
			S_DONE: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.state     = state_q;
		ctrl.req_ready = (state_q == S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BOOT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/commit_window_tracker_top.sv -----
// Top level of the commit window tracker: datapath registers, slot memory, shared ALU.
// Depends on cwt_pkg, cwt_alu, cwt_slot_ram, cwt_seq and assert_macros.svh.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  request | req_valid, req_stall, func, commit_id,   | in
//          | succeeded                                |
//  result  | rsp_valid, rsp_stall, snapshot_id,       | out
//          | gap_error                                |
//
// Commit: slot write, after a seven-step index reduction unless RING_SLOTS is a power of two.
// Snapshot: tests slots in turn, then may advance the base; check: tests up to RING_SLOTS-1 slots.
// Start window: a clearing pass through the slot memory, one slot a cycle.
// After reset the same clearing pass runs with req_stall high.
// One request at a time; the result register lets the next request in while rsp_stall holds.
`include "assert_macros.svh"

module commit_window_tracker_top import cwt_pkg::*; #(
	parameter int RING_SLOTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [2:0]       func,
	input  logic [ID_W-1:0]  commit_id,
	input  logic             succeeded,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [ID_W-1:0]  snapshot_id,
	output logic             gap_error
);

	localparam int IW      = $clog2(RING_SLOTS);
	localparam bit IS_POW2 = ((1 << IW) == RING_SLOTS);

	// 2^(16k) mod RING_SLOTS per 16-bit digit, and a 30-bit reciprocal of RING_SLOTS
	localparam logic [11:0] MOD_W1  = 12'((64'd1 << 16) % 64'(RING_SLOTS));
	localparam logic [11:0] MOD_W2  = 12'((64'(MOD_W1) * 64'(MOD_W1)) % 64'(RING_SLOTS));
	localparam logic [11:0] MOD_W3  = 12'((64'(MOD_W2) * 64'(MOD_W1)) % 64'(RING_SLOTS));
	localparam logic [29:0] MOD_INV = 30'((64'd1 << 30) / 64'(RING_SLOTS));
	localparam logic [2:0]  MOD_STEP_RECIP = 3'd4;
	localparam logic [2:0]  MOD_STEP_FOLD  = 3'd5;
	localparam logic [2:0]  MOD_STEP_FIX   = 3'd6;

	ctrl_t   ctrl;
	status_t st;

	logic [ID_W-1:0]  base_q, id_q, test_q, last_q, out_id_q;
	logic [IW-1:0]    base_idx_q, walk_idx_q, last_idx_q, rem_q, cnt_q;
	logic [IW-1:0]    idx_src, idx_next, waddr;
	logic [2:0]       mod_step_q;
	logic [29:0]      mod_acc_q, mod_quo_q, mod_prod, mod_qm;
	logic [15:0]      mod_digit;
	logic [11:0]      mod_wt;
	logic [59:0]      mod_recip;
	func_t            func_q;
	logic             missed_q, gap_q, out_valid_q, out_gap_q;
	logic             accept, out_free, we, walk_last, advance;
	logic [ID_W-1:0]  wdata, rdata, alu_a, alu_b, alu_y;
	alu_op_t          alu_op;
	logic             alu_borrow, alu_zero;

	assign accept   = req_valid && ctrl.req_ready;
	assign out_free = !out_valid_q || !rsp_stall;
	assign advance  = |alu_y[ID_W-1:ADV_LOG2];

	assign walk_last = (func_q == F_CHECK) ? (cnt_q == IW'(RING_SLOTS - 2))
	                                       : (cnt_q == IW'(RING_SLOTS - 1));

	always_comb begin
		idx_src  = (ctrl.state == S_WSTART) ? base_idx_q : walk_idx_q;
		idx_next = (idx_src == IW'(RING_SLOTS - 1)) ? '0 : idx_src + IW'(1);
	end

	// weighted digit sum, reciprocal estimate and quotient fold for the slot index
	always_comb begin
		mod_digit = id_q[{mod_step_q[1:0], 4'd0} +: 16];
		case (mod_step_q[1:0])
			2'd0:    mod_wt = 12'd1;
			2'd1:    mod_wt = MOD_W1;
			2'd2:    mod_wt = MOD_W2;
			default: mod_wt = MOD_W3;
		endcase
		mod_prod  = {14'd0, mod_digit} * {18'd0, mod_wt};
		mod_recip = {30'd0, mod_acc_q} * {30'd0, MOD_INV};
		mod_qm    = mod_quo_q * 30'(RING_SLOTS);
	end

	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = test_q;
		alu_b  = ID_W'(1);
		case (ctrl.state)
			S_MOD: begin
				alu_a = ID_W'(mod_acc_q);
				case (mod_step_q)
					MOD_STEP_FOLD: begin
						alu_op = ALU_SUB;
						alu_b  = ID_W'(mod_qm);
					end
					MOD_STEP_FIX: begin
						alu_op = ALU_SUB;
						alu_b  = ID_W'(RING_SLOTS);
					end
					default: alu_b = ID_W'(mod_prod);
				endcase
			end
			S_WSTART: alu_a = base_q;
			S_WCMP: begin
				alu_op = ALU_SUB;
				alu_a  = rdata;
				alu_b  = test_q;
			end
			S_ADV: begin
				alu_op = ALU_SUB;
				alu_a  = last_q;
				alu_b  = base_q;
			end
			default: alu_a = test_q;
		endcase
	end

	always_comb begin
		we    = (ctrl.state == S_WRITE) || (ctrl.state == S_CLR) || (ctrl.state == S_BOOT);
		waddr = (ctrl.state == S_WRITE) ? rem_q : cnt_q;
		wdata = (ctrl.state == S_WRITE) ? id_q : '0;
	end

	always_comb begin
		st.req_valid  = req_valid;
		st.req_func   = func_t'(func);
		st.cur_func   = func_q;
		st.succeeded  = succeeded;
		st.pow2       = IS_POW2;
		st.out_free   = out_free;
		st.mod_last   = (mod_step_q == MOD_STEP_FIX);
		st.sweep_last = (cnt_q == IW'(RING_SLOTS - 1));
		st.walk_last  = walk_last;
		st.tag_eq     = alu_zero;
		st.missed     = missed_q;
	end

	cwt_alu u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.y      (alu_y),
		.borrow (alu_borrow),
		.zero   (alu_zero)
	);

	cwt_slot_ram #(
		.DEPTH (RING_SLOTS),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (idx_next),
		.rdata (rdata)
	);

	cwt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctrl   (ctrl)
	);

	// payload registers
	always_ff @(posedge clk) begin
		case (ctrl.state)
			S_IDLE: begin
				if (accept) begin
					id_q       <= commit_id;
					mod_step_q <= '0;
					mod_acc_q  <= '0;
					rem_q      <= IS_POW2 ? commit_id[IW-1:0] : '0;
				end
			end
			S_MOD: begin
				mod_step_q <= mod_step_q + 3'd1;
				case (mod_step_q)
					MOD_STEP_RECIP: mod_quo_q <= mod_recip[59:30];
					MOD_STEP_FIX:   rem_q <= alu_borrow ? mod_acc_q[IW-1:0] : alu_y[IW-1:0];
					default:        mod_acc_q <= alu_y[29:0];
				endcase
			end
			S_WSTART: begin
				test_q     <= alu_y;
				last_q     <= base_q;
				last_idx_q <= base_idx_q;
				walk_idx_q <= idx_next;
			end
			S_WCMP: begin
				if (alu_zero && !(func_q == F_CHECK && missed_q)) begin
					last_q     <= test_q;
					last_idx_q <= walk_idx_q;
				end
			end
			S_WINC: begin
				test_q     <= alu_y;
				walk_idx_q <= idx_next;
			end
			S_DONE: begin
				if (out_free) begin
					if (func_q == F_SNAP || func_q == F_CHECK) out_id_q <= last_q;
					else if (func_q == F_START || func_q == F_SETB) out_id_q <= id_q;
					else out_id_q <= base_q;
					out_gap_q <= gap_q;
				end
			end
			default: begin
			end
		endcase
	end

	// control state and window base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			base_idx_q  <= '0;
			cnt_q       <= '0;
			func_q      <= F_COMMIT;
			missed_q    <= 1'b0;
			gap_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.state == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (ctrl.state)
				S_BOOT, S_CLR: cnt_q <= cnt_q + IW'(1);
				S_IDLE: begin
					if (accept) begin
						func_q   <= func_t'(func);
						cnt_q    <= '0;
						missed_q <= 1'b0;
						gap_q    <= 1'b0;
					end
				end
				S_WCMP: begin
					if (!alu_zero) missed_q <= 1'b1;
					else if (func_q == F_CHECK && missed_q) gap_q <= 1'b1;
				end
				S_WINC: cnt_q <= cnt_q + IW'(1);
				S_ADV: begin
					if (advance) begin
						base_q     <= last_q;
						base_idx_q <= last_idx_q;
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (func_q == F_START || func_q == F_SETB) begin
							base_q     <= id_q;
							base_idx_q <= rem_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign req_stall   = !ctrl.req_ready;
	assign rsp_valid   = out_valid_q;
	assign snapshot_id = out_id_q;
	assign gap_error   = out_gap_q;

	`CWT_ASSERT_IMP(a_busy_stall, ctrl.state != S_IDLE, req_stall, "request taken while busy")
	`CWT_ASSERT(a_base_idx_range, base_idx_q <= IW'(RING_SLOTS - 1), "base slot out of range")
	`CWT_ASSERT_IMP(a_base_idx_pow2, IS_POW2, base_idx_q == base_q[IW-1:0], "base slot mismatch")
	`CWT_ASSERT_IMP(a_gap_check, gap_q, func_q == F_CHECK, "gap flagged outside check")

endmodule
